// ===== src/slip_pkg.sv =====
// Shared types and constants for the SLIP frame decoder.
// Used by slip_byte_decoder and slip_frame_decoder; depends on nothing else.
package slip_pkg;

    // Largest frame the decoder will keep, in decoded bytes.
    localparam int MAX_FRAME_BYTES = 128;

    // The effective length limit never exceeds what an 8-bit count can hold.
    localparam int LIMIT_CAP_INT = (MAX_FRAME_BYTES > 255) ? 255 : MAX_FRAME_BYTES;
    localparam logic [7:0] LIMIT_CAP = 8'(LIMIT_CAP_INT);

    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 8;

    // SLIP special codes.
    localparam logic [7:0] CODE_END     = 8'hC0;
    localparam logic [7:0] CODE_ESC     = 8'hDB;
    localparam logic [7:0] CODE_ESC_END = 8'hDC;
    localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_FRAME_LEN = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_FRAME_LEN = CFG_ADDR_W'(1);

    // Reset values of the configuration registers.
    localparam logic [7:0] MIN_FRAME_LEN_RST = 8'd4;
    localparam logic [7:0] MAX_FRAME_LEN_RST = 8'd128;

    typedef enum logic [1:0] {
        STATUS_GOOD     = 2'd0,
        STATUS_SHORT    = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } frame_status_t;

    typedef struct packed {
        logic [7:0]    data;
        logic [7:0]    position;
        logic          frame_end;
        frame_status_t status;
    } slip_result_t;

    typedef struct packed {
        logic [7:0] min_frame_len;
        logic [7:0] max_frame_len;
    } slip_cfg_t;

endpackage

// ===== src/slip_frame_decoder.sv =====
// Top level of the SLIP frame decoder: stream ports, configuration registers,
// input and result registers. Depends on slip_pkg and slip_byte_decoder.

// SLIP receive decoder. Raw line bytes arrive one per transaction on the s_axis
// port; every decoded data byte leaves on m_axis with its 0-based position in
// the frame, and every END byte leaves an end-of-frame transaction (tlast high)
// that carries the frame length in the position field and a status in tuser:
// good, short (fewer bytes than min_frame_len) or overflow (bytes past the
// limit were dropped; overflow wins over short). The length limit is the
// lower of max_frame_len and MAX_FRAME_BYTES. ESC bytes, and data bytes dropped
// by overflow, produce no output transaction. The block sustains one byte per
// clock while m_axis is not stalled: each byte passes through an input register
// and then the combinational decode logic into the result register, which
// presents the result on m_axis until it is taken. Back-pressure from
// m_axis_tready reaches s_axis_tready in the same cycle. Configuration writes
// take effect at once and should only be made while no byte is in flight.
module slip_frame_decoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input stream: tdata[7:0] in_byte.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,
    // Result stream: tdata[7:0] out_byte, tdata[15:8] out_position.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [15:0]                      m_axis_tdata,
    output logic                             m_axis_tlast,
    // tuser[1:0] frame_status.
    output logic [1:0]                       m_axis_tuser,
    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [slip_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [slip_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import slip_pkg::*;

    slip_cfg_t    cfg_reg;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    slip_result_t out_reg;

    logic         res_valid;
    slip_result_t res;
    logic         out_free;
    logic         step;

    // The result register can take a new value when it is empty or being read.
    assign out_free = !out_valid_reg || m_axis_tready;
    // A held byte moves on when it yields nothing or the result register is free.
    assign step     = in_valid_reg && (!res_valid || out_free);
    assign s_axis_tready = !in_valid_reg || step;

    slip_byte_decoder u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .in_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Configuration registers; writes to unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_frame_len <= MIN_FRAME_LEN_RST;
            cfg_reg.max_frame_len <= MAX_FRAME_LEN_RST;
        end else if (cfg_we) begin
            if (cfg_addr == REG_MIN_FRAME_LEN) begin
                cfg_reg.min_frame_len <= cfg_wdata;
            end else if (cfg_addr == REG_MAX_FRAME_LEN) begin
                cfg_reg.max_frame_len <= cfg_wdata;
            end
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && step && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.position, out_reg.data};
    assign m_axis_tlast  = out_reg.frame_end;
    assign m_axis_tuser  = out_reg.status;

    // A data result never carries a status.
    a_data_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == STATUS_GOOD))
        else $error("data result with non-zero status");

    // A data byte's position always lies below the hard length cap.
    a_position_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[15:8] < LIMIT_CAP))
        else $error("data position beyond frame cap");

    // A held byte that cannot move stays in the input register.
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !step) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled input byte lost");

    // The result register only fills from a decoded result.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg && !(step && res_valid)) |=> !out_valid_reg)
        else $error("result appeared without a decoded byte");

endmodule

// ===== src/slip_byte_decoder.sv =====
// Per-byte SLIP decode logic and the frame state (escape flag, count, overflow).
// Depends on slip_pkg.
module slip_byte_decoder (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [7:0]            in_byte,
    input  slip_pkg::slip_cfg_t   cfg,
    output logic                  res_valid,
    output slip_pkg::slip_result_t res
);
    import slip_pkg::*;

    logic       escape_pending_reg, escape_pending_next;
    logic [7:0] byte_count_reg, byte_count_next;
    logic       overflowed_reg, overflowed_next;
    logic [7:0] limit;
    logic [7:0] decoded;

    assign limit = (cfg.max_frame_len < LIMIT_CAP) ? cfg.max_frame_len : LIMIT_CAP;

    always_comb begin
        escape_pending_next = escape_pending_reg;
        byte_count_next     = byte_count_reg;
        overflowed_next     = overflowed_reg;
        res_valid           = 1'b0;
        res                 = '{data: 8'd0, position: byte_count_reg,
                                frame_end: 1'b0, status: STATUS_GOOD};
        decoded             = in_byte;

        if (in_byte == CODE_END) begin
            res_valid     = 1'b1;
            res.frame_end = 1'b1;
            if (overflowed_reg) begin
                res.status = STATUS_OVERFLOW;
            end else if (byte_count_reg < cfg.min_frame_len) begin
                res.status = STATUS_SHORT;
            end
            byte_count_next     = 8'd0;
            overflowed_next     = 1'b0;
            escape_pending_next = 1'b0;
        end else if (in_byte == CODE_ESC) begin
            escape_pending_next = 1'b1;
        end else begin
            // Escaped codes are translated only straight after an ESC.
            if (escape_pending_reg) begin
                if (in_byte == CODE_ESC_END) begin
                    decoded = CODE_END;
                end else if (in_byte == CODE_ESC_ESC) begin
                    decoded = CODE_ESC;
                end
                escape_pending_next = 1'b0;
            end
            if (byte_count_reg >= limit) begin
                overflowed_next = 1'b1;
            end else begin
                res_valid       = 1'b1;
                res.data        = decoded;
                byte_count_next = byte_count_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_pending_reg <= 1'b0;
            byte_count_reg     <= 8'd0;
            overflowed_reg     <= 1'b0;
        end else if (step) begin
            escape_pending_reg <= escape_pending_next;
            byte_count_reg     <= byte_count_next;
            overflowed_reg     <= overflowed_next;
        end
    end

endmodule

// ===== tb/slip_frame_decoder_test.sv =====
// Self-checking testbench for slip_frame_decoder: directed and random SLIP byte streams.
// Depends on slip_pkg and the slip_frame_decoder RTL. It reads no files.
`timescale 1ns / 100ps

module slip_frame_decoder_test;

    import slip_pkg::*;

    // Register indexes that the block does not decode. Writes to them must be ignored.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_LAST  = '1;

    // The block registers each byte and then each result. The drain wait covers
    // a byte in flight and leaves some margin before a register write.
    localparam int DRAIN_CYCLES = 4;

    // The slowest correct run is about 1600 bytes. Each byte can take a random gap
    // and a result stall, and the limit allows several times the worst case.
    localparam int CYCLE_LIMIT = 200000;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;   // [7:0] in_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;         // [7:0] out_byte, [15:8] out_position
    logic                  m_axis_tlast;         // frame_end
    logic [1:0]            m_axis_tuser;         // [1:0] frame_status
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    slip_frame_decoder DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // The testbench keeps its own copy of the decoder state and of the two
    // length registers. The copy is updated when a byte is accepted and when a
    // register is written.
    logic       esc_armed    = 1'b0;
    logic [7:0] kept_count   = '0;
    logic       frame_dropped = 1'b0;
    logic [7:0] cfg_min_len  = MIN_FRAME_LEN_RST;
    logic [7:0] cfg_max_len  = MAX_FRAME_LEN_RST;

    // Decoded bytes and end markers that are still to come, oldest first.
    slip_result_t pending_results[$];

    int  errors      = 0;
    int  bytes_sent  = 0;
    int  cycle_count = 0;
    // When set, both the sender and the result sink run without any idle cycles.
    bit  steady      = 1'b0;

    // Works out what one raw line byte produces. It returns 1 and fills res
    // when the byte gives a transaction on the result side.
    function automatic bit decode_byte(input logic [7:0] raw, output slip_result_t res);
        logic [7:0] data;
        logic [7:0] limit;
        data  = raw;
        res   = '0;
        limit = (cfg_max_len > LIMIT_CAP) ? LIMIT_CAP : cfg_max_len;
        if (raw == CODE_END) begin
            // END closes the frame whatever state it is in. Overflow takes
            // priority over short.
            res.frame_end = 1'b1;
            res.position  = kept_count;
            if (frame_dropped)
                res.status = STATUS_OVERFLOW;
            else if (kept_count < cfg_min_len)
                res.status = STATUS_SHORT;
            else
                res.status = STATUS_GOOD;
            kept_count    = '0;
            frame_dropped = 1'b0;
            esc_armed     = 1'b0;
            return 1'b1;
        end
        if (raw == CODE_ESC) begin
            esc_armed = 1'b1;
            return 1'b0;
        end
        if (esc_armed) begin
            // A bad escape keeps the byte as it is. Only the two escape codes are translated.
            if (raw == CODE_ESC_END)
                data = CODE_END;
            else if (raw == CODE_ESC_ESC)
                data = CODE_ESC;
            esc_armed = 1'b0;
        end
        if (kept_count >= limit) begin
            frame_dropped = 1'b1;
            return 1'b0;
        end
        res.data     = data;
        res.position = kept_count;
        kept_count   = kept_count + 8'd1;
        return 1'b1;
    endfunction

    // Sends one raw byte, after a random gap unless steady is set, and records what it should produce.
    // tvalid stays high on return. Either the next call follows in the same
    // time step, or drain lowers it.
    task automatic send_byte(input logic [7:0] raw);
        int           gap;
        slip_result_t res;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        do @(posedge aclk); while (!s_axis_tready);
        if (decode_byte(raw, res))
            pending_results.push_back(res);
        bytes_sent++;
    endtask

    // Sends one payload byte with SLIP stuffing, so that END and ESC go out as escape pairs.
    task automatic send_payload(input logic [7:0] data);
        if (data == CODE_END) begin
            send_byte(CODE_ESC);
            send_byte(CODE_ESC_END);
        end else if (data == CODE_ESC) begin
            send_byte(CODE_ESC);
            send_byte(CODE_ESC_ESC);
        end else begin
            send_byte(data);
        end
    endtask

    // Stops the sender, waits until every expected result has arrived, and
    // then waits on for any byte still inside the block: a trailing ESC or a
    // dropped byte gives no result but may still be there.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register writes are made only when the decoder is idle.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_MIN_FRAME_LEN: cfg_min_len = value;
            REG_MAX_FRAME_LEN: cfg_max_len = value;
            default: ;
        endcase
    endtask

    // Random line byte. The four SLIP codes come up far more often than they
    // would by chance.
    function automatic logic [7:0] line_byte();
        case ($urandom_range(0, 7))
            0:       return CODE_END;
            1:       return CODE_ESC;
            2:       return CODE_ESC_END;
            3:       return CODE_ESC_ESC;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Runs with the reset register values (minimum 4, maximum 128). A short
    // frame carrying the extreme byte values, then an empty frame.
    task automatic test_reset_defaults();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(CODE_END);
        send_byte(CODE_END);
    endtask

    // Escape handling. Both escape pairs, then the escape codes with no ESC in
    // front of them, a bad escape and a doubled ESC. The frame is then closed
    // by an END that arrives while an escape is still pending.
    task automatic test_escape_codes();
        send_byte(CODE_ESC);
        send_byte(CODE_ESC_END);
        send_byte(CODE_ESC);
        send_byte(CODE_ESC_ESC);
        send_byte(CODE_ESC_END);
        send_byte(CODE_ESC_ESC);
        send_byte(CODE_ESC);
        send_byte(8'h41);
        send_byte(CODE_ESC);
        send_byte(CODE_ESC);
        send_byte(CODE_ESC_END);
        send_byte(CODE_ESC);
        send_byte(CODE_END);
    endtask

    // Length limits. A frame that runs past a small limit, with an escape
    // pair among the dropped bytes. Then a limit of zero together with a
    // short threshold of 128. Writes to the undecoded indexes must leave
    // both registers as they are.
    task automatic test_length_limits();
        write_reg(REG_MIN_FRAME_LEN, 8'd0);
        write_reg(REG_MAX_FRAME_LEN, 8'd2);
        send_byte(8'h11);
        send_byte(CODE_ESC);
        send_byte(8'h22);
        send_byte(8'h33);
        send_byte(CODE_ESC);
        send_byte(CODE_ESC_END);
        send_byte(CODE_END);
        write_reg(REG_MAX_FRAME_LEN, 8'd0);
        write_reg(REG_MIN_FRAME_LEN, 8'd128);
        write_reg(REG_SPARE, 8'h00);
        write_reg(REG_LAST, 8'h01);
        send_byte(CODE_END);
        send_byte(8'h5A);
        send_byte(CODE_END);
    endtask

    // Random traffic over several register settings, the extremes among them.
    // Most of it is stuffed frames with random content and a closing END. A
    // few frames run past the 128-byte limit. The rest is line noise and
    // frames that lose their END and run into the next frame.
    task automatic test_random_traffic();
        int         frame_len;
        int         roll;
        int         budget;
        bit         paused;
        logic [7:0] min_sel;
        logic [7:0] max_sel;
        paused = 1'b0;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       begin min_sel = 8'd4;   max_sel = 8'd128; end
                1:       begin min_sel = 8'd0;   max_sel = 8'd1;   end
                2:       begin min_sel = 8'd128; max_sel = 8'd128; end
                3:       begin min_sel = 8'd0;   max_sel = 8'd255; end
                4:       begin min_sel = 8'd255; max_sel = 8'd7;   end
                5:       begin min_sel = 8'd3;   max_sel = 8'd0;   end
                default: begin
                    min_sel = 8'($urandom_range(0, 255));
                    max_sel = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(REG_MIN_FRAME_LEN, min_sel);
            write_reg(REG_MAX_FRAME_LEN, max_sel);
            steady = (phase % 3 == 2);
            budget = bytes_sent + 145;
            while (bytes_sent < budget) begin
                roll = $urandom_range(0, 11);
                frame_len = (roll == 0) ? $urandom_range(100, 135) : $urandom_range(0, 12);
                for (int i = 0; i < frame_len; i++) begin
                    if ($urandom_range(0, 15) == 0)
                        send_byte(line_byte());
                    else
                        send_payload(line_byte());
                end
                if (roll != 1)
                    send_byte(CODE_END);
                // Halfway through the first phase the sender waits until the
                // block has returned every result.
                if (phase == 0 && !paused && bytes_sent > budget - 72) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end
        steady = 1'b0;
    endtask

    // Result sink. Before each transaction it holds tready low for a random
    // number of cycles, except in steady stretches.
    always begin : result_sink
        int stall;
        stall = steady ? 0 : $urandom_range(0, 7);
        if (stall > 0) begin
            m_axis_tready <= 1'b0;
            repeat (stall) @(posedge aclk);
        end
        m_axis_tready <= 1'b1;
        do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
    end

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Checks every result transaction against the oldest expectation.
    always @(posedge aclk) begin : result_check
        slip_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual data %0d pos %0d end %0d",
                         $time, m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast);
                errors++;
            end else begin
                want = pending_results.pop_front();
                report_field("out_byte", want.data, m_axis_tdata[7:0]);
                report_field("out_position", want.position, m_axis_tdata[15:8]);
                report_field("frame_end", 8'(want.frame_end), 8'(m_axis_tlast));
                report_field("frame_status", 8'(want.status), 8'(m_axis_tuser));
            end
        end
    end

    // Timeout guard for a block that hangs or drops results.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_escape_codes();
        test_length_limits();
        test_random_traffic();
        drain();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
src/slip_pkg.sv
src/slip_byte_decoder.sv
src/slip_frame_decoder.sv
tb/slip_frame_decoder_test.sv
